### hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helper functions shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

	localparam int FRAC_BITS_DEF = 8;
	// quotient bits kept by the divider; anything larger saturates anyway
	localparam int QBITS = 17;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef struct packed {
		logic [32:0]      rem;
		logic [QBITS-1:0] q;
		logic [QBITS-1:0] low;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef struct packed {
		logic        is_div;
		logic        dz;
		logic [15:0] re;
		logic [15:0] im;
		logic        sat;
		logic [31:0] d;
		lane_t       lre;
		lane_t       lim;
	} item_t;

	// clip a 33-bit signed value to 16 bits: {clipped, value}
	function automatic logic [16:0] sat16(logic signed [32:0] v);
		logic [16:0] r;
		if (v > 33'sd32767)
			r = {1'b1, 16'h7fff};
		else if (v < -33'sd32768)
			r = {1'b1, 16'h8000};
		else
			r = {1'b0, v[15:0]};
		return r;
	endfunction

	// one restoring division step
	function automatic lane_t div_step(lane_t l, logic [31:0] d);
		logic [32:0] r;
		lane_t o;
		o = l;
		r = {l.rem[31:0], l.low[QBITS-1]};
		o.low = {l.low[QBITS-2:0], 1'b0};
		if (r >= {1'b0, d}) begin
			o.rem = r - {1'b0, d};
			o.q = {l.q[QBITS-2:0], 1'b1};
		end else begin
			o.rem = r;
			o.q = {l.q[QBITS-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

`default_nettype wire

### hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Products, sums, add/subtract/multiply results and divider setup (3 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               up_valid,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] a_re,
	input  wire logic signed [15:0] a_im,
	input  wire logic signed [15:0] b_re,
	input  wire logic signed [15:0] b_im,
	output logic                    dn_valid,
	output cau_pkg::item_t          dn_item
);

	// stage 1
	logic                v_s1;
	cau_pkg::kind_t      kind_s1;
	logic signed [31:0]  p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, sq_r_s1, sq_i_s1;
	logic signed [16:0]  lin_re_s1, lin_im_s1;

	// stage 2
	logic                v_s2;
	logic                is_div_s2;
	logic [15:0]         re_s2, im_s2;
	logic                sat_s2;
	logic [31:0]         d_s2;
	logic [31:0]         mre_s2, mim_s2;
	logic                nre_s2, nim_s2;

	logic signed [16:0]  lin_re, lin_im;
	logic signed [32:0]  mre, mim, nre, nim, sh_re, sh_im;
	logic [16:0]         cre, cim;
	logic [63:0]         mx_re, mx_im, hi_re, hi_im;

	always_comb begin
		if (cau_pkg::kind_t'(kind) == cau_pkg::KIND_SUB) begin
			lin_re = {a_re[15], a_re} - {b_re[15], b_re};
			lin_im = {a_im[15], a_im} - {b_im[15], b_im};
		end else begin
			lin_re = {a_re[15], a_re} + {b_re[15], b_re};
			lin_im = {a_im[15], a_im} + {b_im[15], b_im};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1   <= cau_pkg::kind_t'(kind);
			p_rr_s1   <= 32'(a_re) * 32'(b_re);
			p_ii_s1   <= 32'(a_im) * 32'(b_im);
			p_ri_s1   <= 32'(a_re) * 32'(b_im);
			p_ir_s1   <= 32'(a_im) * 32'(b_re);
			sq_r_s1   <= 32'(b_re) * 32'(b_re);
			sq_i_s1   <= 32'(b_im) * 32'(b_im);
			lin_re_s1 <= lin_re;
			lin_im_s1 <= lin_im;
		end
	end

	always_comb begin
		mre   = {p_rr_s1[31], p_rr_s1} - {p_ii_s1[31], p_ii_s1};
		mim   = {p_ri_s1[31], p_ri_s1} + {p_ir_s1[31], p_ir_s1};
		nre   = {p_rr_s1[31], p_rr_s1} + {p_ii_s1[31], p_ii_s1};
		nim   = {p_ir_s1[31], p_ir_s1} - {p_ri_s1[31], p_ri_s1};
		sh_re = mre >>> FRAC_BITS;
		sh_im = mim >>> FRAC_BITS;
		if (kind_s1 == cau_pkg::KIND_MUL) begin
			cre = cau_pkg::sat16(sh_re);
			cim = cau_pkg::sat16(sh_im);
		end else begin
			cre = cau_pkg::sat16(33'(lin_re_s1));
			cim = cau_pkg::sat16(33'(lin_im_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			is_div_s2 <= (kind_s1 == cau_pkg::KIND_DIV);
			re_s2     <= cre[15:0];
			im_s2     <= cim[15:0];
			sat_s2    <= cre[16] | cim[16];
			d_s2      <= $unsigned(sq_r_s1) + $unsigned(sq_i_s1);
			nre_s2    <= nre[32];
			nim_s2    <= nim[32];
			mre_s2    <= nre[32] ? 32'(-nre) : nre[31:0];
			mim_s2    <= nim[32] ? 32'(-nim) : nim[31:0];
		end
	end

	// stage 3: scale the dividend, flag quotients that cannot fit
	always_comb begin
		mx_re = 64'(mre_s2) << FRAC_BITS;
		mx_im = 64'(mim_s2) << FRAC_BITS;
		hi_re = mx_re >> cau_pkg::QBITS;
		hi_im = mx_im >> cau_pkg::QBITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (en) begin
			dn_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_item.is_div  <= is_div_s2;
			dn_item.dz      <= is_div_s2 && (d_s2 == 32'd0);
			dn_item.re      <= re_s2;
			dn_item.im      <= im_s2;
			dn_item.sat     <= sat_s2;
			dn_item.d       <= d_s2;
			dn_item.lre.neg <= nre_s2;
			dn_item.lim.neg <= nim_s2;
			dn_item.lre.ovf <= hi_re >= 64'(d_s2);
			dn_item.lim.ovf <= hi_im >= 64'(d_s2);
			dn_item.lre.rem <= (hi_re >= 64'(d_s2)) ? 33'd0 : hi_re[32:0];
			dn_item.lim.rem <= (hi_im >= 64'(d_s2)) ? 33'd0 : hi_im[32:0];
			dn_item.lre.low <= mx_re[cau_pkg::QBITS-1:0];
			dn_item.lim.low <= mx_im[cau_pkg::QBITS-1:0];
			dn_item.lre.q   <= '0;
			dn_item.lim.q   <= '0;
		end
	end

endmodule

`default_nettype wire

### hdl/cau_div_stage.sv
// ----------------------------------------------------------------------------
// cau_div_stage
// One pipelined restoring division step for both result parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            up_valid,
	input  wire cau_pkg::item_t  up_item,
	output logic                 dn_valid,
	output cau_pkg::item_t       dn_item
);

	cau_pkg::item_t nxt;

	always_comb begin
		nxt     = up_item;
		nxt.lre = cau_pkg::div_step(up_item.lre, up_item.d);
		nxt.lim = cau_pkg::div_step(up_item.lim, up_item.d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid <= 1'b0;
		end else if (en) begin
			dn_valid <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_item <= nxt;
		end
	end

endmodule

`default_nettype wire

### hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide on signed fixed point.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  request  req_valid / req_stall   kind, a_re, a_im, b_re, b_im
//  result   rsp_valid / rsp_stall   res_re, res_im, divide_by_zero, saturated
//
//  One beat per cycle unless the result stalls; 3 front stages, 17 division steps
//  and one output stage, the divider giving one quotient bit per stage.
//  Reset clears all stage valid bits; no other state.
//  A stalled result freezes the whole pipeline and stalls the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit #(
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [15:0] a_re,
	input  wire logic signed [15:0] a_im,
	input  wire logic signed [15:0] b_re,
	input  wire logic signed [15:0] b_im,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic signed [15:0]      res_re,
	output logic signed [15:0]      res_im,
	output logic                    divide_by_zero,
	output logic                    saturated
);

	localparam int N = cau_pkg::QBITS;

	logic           en;
	logic           v_s [N+1];
	cau_pkg::item_t it_s [N+1];
	cau_pkg::item_t fin;
	logic           ovr_re, ovr_im;
	logic [N-1:0]   neg_re, neg_im;

	// advance unless a finished beat is held
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .up_valid(req_valid),
		.kind(kind), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.dn_valid(v_s[0]), .dn_item(it_s[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_div
		cau_div_stage u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(v_s[g]), .up_item(it_s[g]),
			.dn_valid(v_s[g+1]), .dn_item(it_s[g+1])
		);
	end

	assign fin    = it_s[N];
	assign neg_re = -fin.lre.q;
	assign neg_im = -fin.lim.q;
	assign ovr_re = fin.lre.ovf ||
		(fin.lre.neg ? (fin.lre.q > N'(32768)) : (fin.lre.q > N'(32767)));
	assign ovr_im = fin.lim.ovf ||
		(fin.lim.neg ? (fin.lim.q > N'(32768)) : (fin.lim.q > N'(32767)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!fin.is_div) begin
				res_re         <= fin.re;
				res_im         <= fin.im;
				divide_by_zero <= 1'b0;
				saturated      <= fin.sat;
			end else if (fin.dz) begin
				res_re         <= '0;
				res_im         <= '0;
				divide_by_zero <= 1'b1;
				saturated      <= 1'b0;
			end else begin
				if (ovr_re)
					res_re <= fin.lre.neg ? 16'h8000 : 16'h7fff;
				else
					res_re <= fin.lre.neg ? neg_re[15:0] : fin.lre.q[15:0];
				if (ovr_im)
					res_im <= fin.lim.neg ? 16'h8000 : 16'h7fff;
				else
					res_im <= fin.lim.neg ? neg_im[15:0] : fin.lim.q[15:0];
				divide_by_zero <= 1'b0;
				saturated      <= ovr_re | ovr_im;
			end
		end
	end

endmodule

`default_nettype wire
